@@ design/text_console_writer_macros.svh @@
// assertion macros shared by the text console writer
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcw same-cycle check failed");

// next-cycle implication, disabled during reset
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcw next-cycle check failed");

`endif

@@ design/tcw_pkg.sv @@
// package: types, codes and constants of the text console writer
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int ACTION_W  = 3;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int COLUMN_W  = 7;
    localparam int ROW_W     = 5;
    localparam int CELL_W    = 16;
    localparam int ADDRESS_W = 11;

    localparam logic [ACTION_W-1:0] ACT_PUT_CURSOR = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUT_AT     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SET_CURSOR = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'h20;
    localparam logic [COLOR_W-1:0] BLANK_ATTR   = 8'h07;

    typedef enum logic [1:0] {
        SW_NONE,
        SW_COPY,
        SW_FILL,
        SW_CLEAR
    } t_sweep_op;

    typedef struct packed {
        logic      load;
        logic      exec;
        t_sweep_op op;
        logic      push;
    } t_tcw_cmd;

    typedef struct packed {
        logic out_free;
        logic is_clear;
        logic need_scroll;
        logic copy_last;
        logic fill_last;
        logic clear_last;
    } t_tcw_status;

endpackage

@@ design/tcw_if.sv @@
// request and response channel interfaces of the text console writer
interface tcw_in_if import tcw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  color;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;

    modport source (output valid, action, char_code, color, column, row, input ready);
    modport sink (input valid, action, char_code, color, column, row, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_word;
    logic [COLUMN_W-1:0]  cursor_col;
    logic [ROW_W-1:0]     cursor_row;
    logic [ADDRESS_W-1:0] cursor_address;
    logic                 scrolled;

    modport source (output valid, cell_word, cursor_col, cursor_row, cursor_address, scrolled,
                    input ready);
    modport sink (input valid, cell_word, cursor_col, cursor_row, cursor_address, scrolled,
                  output ready);
endinterface

@@ design/tcw_ctrl.sv @@
// controller state machine: sequences execute, scroll, clear and result push
module tcw_ctrl import tcw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_tcw_status i_status,
    output logic        o_ready,
    output t_tcw_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_FILL,
        S_CLEAR,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{load: 1'b0, exec: 1'b0, op: SW_NONE, push: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_clear) begin
                    n_state = S_CLEAR;
                end else if (i_status.need_scroll) begin
                    n_state = S_COPY;
                end else if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_COPY: begin
                o_cmd.op = SW_COPY;
                if (i_status.copy_last) n_state = S_FILL;
            end
            S_FILL: begin
                o_cmd.op = SW_FILL;
                if (i_status.fill_last) n_state = S_FINISH;
            end
            S_CLEAR: begin
                o_cmd.op = SW_CLEAR;
                if (i_status.clear_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_ready = r_ready && (r_state == S_IDLE);

endmodule

@@ design/tcw_dpath.sv @@
// datapath: screen memory, cursor, operand and result registers
module tcw_dpath import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tcw_cmd             i_cmd,
    output t_tcw_status          o_status,
    input  logic [ACTION_W-1:0]  i_action,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [COLOR_W-1:0]   i_color,
    input  logic [COLUMN_W-1:0]  i_column,
    input  logic [ROW_W-1:0]     i_row,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [CELL_W-1:0]    o_cell_word,
    output logic [COLUMN_W-1:0]  o_cursor_col,
    output logic [ROW_W-1:0]     o_cursor_row,
    output logic [ADDRESS_W-1:0] o_cursor_address,
    output logic                 o_scrolled
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int LAST  = CELLS - COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(CELLS + 1);
    localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, CH_SPACE};

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [RW-1:0] r);
        return AW'(r) * AW'(COLUMNS) + AW'(c);
    endfunction

    logic [CELL_W-1:0]   r_cells [CELLS];
    logic [CELL_W-1:0]   r_rd_data;

    logic [ACTION_W-1:0] r_act;
    logic [CHAR_W-1:0]   r_ch;
    logic [COLOR_W-1:0]  r_color;
    logic                r_in_range;
    logic [CW-1:0]       r_tcol;
    logic [RW-1:0]       r_trow;
    logic [AW-1:0]       r_taddr;

    logic [CW-1:0]       r_ccol;
    logic [RW-1:0]       r_crow;
    logic [CW-1:0]       n_ccol;
    logic [RW-1:0]       n_crow;
    logic                r_scrolled;
    logic                n_scrolled;
    logic [IW-1:0]       r_idx;

    logic                r_out_valid;
    logic [CELL_W-1:0]   r_out_cell;
    logic [COLUMN_W-1:0] r_out_col;
    logic [ROW_W-1:0]    r_out_row;
    logic [ADDRESS_W-1:0] r_out_addr;
    logic                r_out_scrolled;

    logic                w_in_range;
    logic [AW-1:0]       w_in_addr;
    logic [CW:0]         w_nx;
    logic [RW:0]         w_ny;
    logic                w_scroll;
    logic                w_item_we;
    logic [AW-1:0]       w_item_addr;
    logic [CELL_W-1:0]   w_item_data;
    logic                w_we;
    logic [AW-1:0]       w_wr_addr;
    logic [CELL_W-1:0]   w_wr_data;
    logic                w_re;
    logic [AW-1:0]       w_rd_addr;

    assign w_in_range = (int'(i_column) < COLUMNS) && (int'(i_row) < ROWS);
    assign w_in_addr  = addr_of(CW'(i_column), RW'(i_row));

    // cursor motion and the single cell write of one operation
    always_comb begin
        w_nx        = {1'b0, r_ccol};
        w_ny        = {1'b0, r_crow};
        w_scroll    = 1'b0;
        w_item_we   = 1'b0;
        w_item_addr = r_taddr;
        w_item_data = {r_color, r_ch};
        unique case (r_act)
            ACT_PUT_CURSOR: begin
                if (r_ch == CH_NEWLINE) begin
                    w_nx = '0;
                    w_ny = (RW+1)'(r_crow) + (RW+1)'(1);
                end else if (r_ch == CH_BACKSPACE) begin
                    if (r_ccol != '0) begin
                        w_nx = (CW+1)'(r_ccol) - (CW+1)'(1);
                    end else if (r_crow != '0) begin
                        w_ny = (RW+1)'(r_crow) - (RW+1)'(1);
                        w_nx = (CW+1)'(COLUMNS - 1);
                    end
                    w_item_we   = 1'b1;
                    w_item_data = {r_color, CH_SPACE};
                    w_item_addr = addr_of(CW'(w_nx), RW'(w_ny));
                end else begin
                    w_item_we   = 1'b1;
                    w_item_addr = addr_of(r_ccol, r_crow);
                    w_nx        = (CW+1)'(r_ccol) + (CW+1)'(1);
                end
                if (w_nx == (CW+1)'(COLUMNS)) begin
                    w_nx = '0;
                    w_ny = w_ny + (RW+1)'(1);
                end
                if (w_ny == (RW+1)'(ROWS)) begin
                    w_ny     = (RW+1)'(ROWS - 1);
                    w_scroll = 1'b1;
                end
            end
            ACT_PUT_AT: begin
                w_item_we = r_in_range;
            end
            ACT_SET_CURSOR: begin
                if (r_in_range) begin
                    w_nx = {1'b0, r_tcol};
                    w_ny = {1'b0, r_trow};
                end
            end
            ACT_CLEAR: begin
                w_nx = '0;
                w_ny = '0;
            end
            default: begin
            end
        endcase
    end

    // memory port selection
    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = w_item_addr;
        w_wr_data = w_item_data;
        w_re      = 1'b0;
        w_rd_addr = w_in_addr;
        unique case (i_cmd.op)
            SW_COPY: begin
                w_we      = (r_idx != '0);
                w_wr_addr = AW'(r_idx - IW'(1));
                w_wr_data = r_rd_data;
                w_re      = (r_idx < IW'(LAST));
                w_rd_addr = AW'(r_idx + IW'(COLUMNS));
            end
            SW_FILL: begin
                w_we      = 1'b1;
                w_wr_addr = AW'(r_idx - IW'(1));
                w_wr_data = BLANK_CELL;
            end
            SW_CLEAR: begin
                w_we      = 1'b1;
                w_wr_addr = AW'(r_idx);
                w_wr_data = BLANK_CELL;
            end
            default: begin
                w_we = i_cmd.exec && w_item_we;
                w_re = i_cmd.load && w_in_range;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_cells[w_wr_addr] <= w_wr_data;
        if (w_re) r_rd_data <= r_cells[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act      <= i_action;
            r_ch       <= i_char_code;
            r_color    <= i_color;
            r_in_range <= w_in_range;
            r_tcol     <= CW'(i_column);
            r_trow     <= RW'(i_row);
            r_taddr    <= w_in_addr;
        end
    end

    assign n_ccol     = i_cmd.exec ? CW'(w_nx) : r_ccol;
    assign n_crow     = i_cmd.exec ? RW'(w_ny) : r_crow;
    assign n_scrolled = i_cmd.exec ? w_scroll : r_scrolled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccol      <= '0;
            r_crow      <= '0;
            r_scrolled  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ccol     <= n_ccol;
            r_crow     <= n_crow;
            r_scrolled <= n_scrolled;
            if (i_cmd.exec) begin
                r_idx <= '0;
            end else if (i_cmd.op != SW_NONE) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_cell     <= (r_act == ACT_READ && r_in_range) ? r_rd_data : '0;
            r_out_col      <= COLUMN_W'(n_ccol);
            r_out_row      <= ROW_W'(n_crow);
            r_out_addr     <= ADDRESS_W'(addr_of(n_ccol, n_crow));
            r_out_scrolled <= n_scrolled;
        end
    end

    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_status.is_clear    = (r_act == ACT_CLEAR);
    assign o_status.need_scroll = w_scroll;
    assign o_status.copy_last   = (r_idx == IW'(LAST));
    assign o_status.fill_last   = (r_idx == IW'(CELLS));
    assign o_status.clear_last  = (r_idx == IW'(CELLS - 1));

    assign o_out_valid      = r_out_valid;
    assign o_cell_word      = r_out_cell;
    assign o_cursor_col     = r_out_col;
    assign o_cursor_row     = r_out_row;
    assign o_cursor_address = r_out_addr;
    assign o_scrolled       = r_out_scrolled;

endmodule

@@ design/text_console_writer.sv @@
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (attribute byte over character
// byte) in one single-port-write memory, plus a cursor. Each request word carries one action
// and yields one response word holding the cursor after the action and its linear address.
// Put, put-at, set-cursor, read and the unused actions pass through an accept step (which
// also issues the memory read) and an execute step. A scroll then moves the screen up one row
// through the memory's read-then-write pipeline, blanks the last row and issues the response;
// a clear blanks every cell, then issues the response. The screen is undefined after reset
// until cleared or written, and no request is taken in the first cycle after reset. A new
// request is taken while the previous response still waits in the output register; that
// request then holds until the output register frees.
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    tcw_in_if.sink   i_req,
    tcw_out_if.source o_rsp
);

    t_tcw_cmd    w_cmd;
    t_tcw_status w_status;
    logic        w_ready;
    logic        w_cursor_ok;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .i_status (w_status),
        .o_ready  (w_ready),
        .o_cmd    (w_cmd)
    );

    tcw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_action         (i_req.action),
        .i_char_code      (i_req.char_code),
        .i_color          (i_req.color),
        .i_column         (i_req.column),
        .i_row            (i_req.row),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_cell_word      (o_rsp.cell_word),
        .o_cursor_col     (o_rsp.cursor_col),
        .o_cursor_row     (o_rsp.cursor_row),
        .o_cursor_address (o_rsp.cursor_address),
        .o_scrolled       (o_rsp.scrolled)
    );

    assign i_req.ready = w_ready;

    assign w_cursor_ok = (int'(o_rsp.cursor_col) < COLUMNS) && (int'(o_rsp.cursor_row) < ROWS);

    `TCW_ASSERT_NOW(a_push_free, i_clk, i_rst_n, w_cmd.push, w_status.out_free)
    `TCW_ASSERT_NOW(a_sweep_blocks, i_clk, i_rst_n, w_cmd.op != SW_NONE, !i_req.ready)
    `TCW_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_req.valid && i_req.ready, w_cmd.exec)
    `TCW_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, o_rsp.valid, w_cursor_ok)

endmodule
